[rtl/stq_pkg.sv]
// Package for the sorted timer queue: sizes, request and result structs,
// status codes, controller states and slot address arithmetic.
// No dependencies.
package stq_pkg;

    // Queue sizing
    localparam int QUEUE_DEPTH  = 16;
    localparam int NAME_CHARS   = 5;
    localparam int NAME_FIELD_W = 40;
    localparam int TIME_W       = 32;
    localparam int NAME_W       = (NAME_CHARS * 8 < NAME_FIELD_W) ? NAME_CHARS * 8
                                                                  : NAME_FIELD_W;
    localparam int ADDR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ADDR_W:0]   DEPTH_X = (ADDR_W + 1)'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [ADDR_W-1:0] A_ONE   = ADDR_W'(1);
    localparam logic [CNT_W-1:0]  C_ONE   = CNT_W'(1);

    // Request kinds
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    typedef enum logic [1:0] {
        ST_EXPIRED  = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_BAD_TIME = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic                    req_type;
        logic signed [TIME_W-1:0] time_value;
        logic [NAME_FIELD_W-1:0] entry_name;
    } in_t;

    typedef struct packed {
        status_t                 status;
        logic [NAME_FIELD_W-1:0] expired_name;
        logic                    last_of_run;
    } out_t;

    // Result handed from the controller to the output register
    typedef struct packed {
        logic valid;
        out_t data;
    } emit_t;

    // One stored entry: absolute deadline against the tick counter, and name
    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [NAME_W-1:0] name;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SCAN,
        S_INS_PLACE,
        S_INS_DONE,
        S_TICK_CHK,
        S_TICK_LAST
    } ctrl_state_t;

    // Physical slot of the entry at queue position off (circular buffer)
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [ADDR_W-1:0] head,
                                                    input logic [ADDR_W-1:0] off);
        logic [ADDR_W:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= DEPTH_X) begin
            sum = sum - DEPTH_X;
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

[rtl/stq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is issued. No dependencies.
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/stq_ctrl.sv]
// Controller of the sorted timer queue: request decode, insertion walk,
// expiry run and entry RAM access. Depends on stq_pkg.
module stq_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  stq_pkg::in_t                in_data,
    input  logic                        can_load,
    output stq_pkg::emit_t              emit,
    output logic                        ram_we,
    output logic [stq_pkg::ADDR_W-1:0]  ram_waddr,
    output stq_pkg::entry_t             ram_wdata,
    output logic                        ram_re,
    output logic [stq_pkg::ADDR_W-1:0]  ram_raddr,
    input  stq_pkg::entry_t             ram_rdata
);

    stq_pkg::ctrl_state_t state_reg, state_next;
    logic [stq_pkg::ADDR_W-1:0]  head_reg, head_next;
    logic [stq_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [stq_pkg::ADDR_W-1:0]  k_reg, k_next;
    logic [stq_pkg::TIME_W-1:0]  now_reg, now_next;
    stq_pkg::entry_t             new_entry_reg, new_entry_next;
    logic [stq_pkg::TIME_W-2:0]  new_rem_reg, new_rem_next;
    stq_pkg::status_t            status_reg, status_next;
    logic [stq_pkg::NAME_W-1:0]  pend_name_reg, pend_name_next;
    logic                        pend_valid_reg, pend_valid_next;

    logic                        t_bad;
    logic                        q_full;
    logic                        q_empty;
    logic [stq_pkg::TIME_W-1:0]  rd_rem;
    logic                        scan_stop;
    logic                        expire;
    logic                        step_ok;
    logic [stq_pkg::CNT_W-1:0]   count_dec;
    logic [stq_pkg::ADDR_W-1:0]  last_off;
    logic [stq_pkg::ADDR_W-1:0]  head_inc;
    logic [stq_pkg::NAME_FIELD_W-1:0] pend_name_ext;

    // Decode request and stored entry
    always_comb
    begin
        t_bad         = (in_data.time_value == '0) || in_data.time_value[stq_pkg::TIME_W-1];
        q_full        = (count_reg == stq_pkg::DEPTH_C);
        q_empty       = (count_reg == '0);
        rd_rem        = ram_rdata.deadline - now_reg;
        scan_stop     = (rd_rem <= {1'b0, new_rem_reg});
        expire        = (ram_rdata.deadline == now_reg);
        step_ok       = !pend_valid_reg || can_load;
        count_dec     = count_reg - stq_pkg::C_ONE;
        last_off      = count_dec[stq_pkg::ADDR_W-1:0];
        head_inc      = stq_pkg::slot_addr(head_reg, stq_pkg::A_ONE);
        pend_name_ext = stq_pkg::NAME_FIELD_W'(pend_name_reg);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stq_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.req_type == stq_pkg::REQ_TICK)
                    begin
                        state_next = q_empty ? stq_pkg::S_IDLE : stq_pkg::S_TICK_CHK;
                    end
                    else if (t_bad || q_full)
                    begin
                        state_next = stq_pkg::S_INS_DONE;
                    end
                    else if (q_empty)
                    begin
                        state_next = stq_pkg::S_INS_PLACE;
                    end
                    else
                    begin
                        state_next = stq_pkg::S_INS_SCAN;
                    end
                end
            end
            stq_pkg::S_INS_SCAN:
            begin
                if (scan_stop || k_reg == stq_pkg::A_ONE)
                begin
                    state_next = stq_pkg::S_INS_PLACE;
                end
            end
            stq_pkg::S_INS_PLACE:
            begin
                state_next = stq_pkg::S_INS_DONE;
            end
            stq_pkg::S_INS_DONE:
            begin
                if (can_load)
                begin
                    state_next = stq_pkg::S_IDLE;
                end
            end
            stq_pkg::S_TICK_CHK:
            begin
                if (step_ok)
                begin
                    if (!expire)
                    begin
                        state_next = stq_pkg::S_IDLE;
                    end
                    else if (count_reg == stq_pkg::C_ONE)
                    begin
                        state_next = stq_pkg::S_TICK_LAST;
                    end
                end
            end
            stq_pkg::S_TICK_LAST:
            begin
                if (can_load)
                begin
                    state_next = stq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = stq_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath updates, RAM access and results
    always_comb
    begin
        in_ready        = 1'b0;
        head_next       = head_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        now_next        = now_reg;
        new_entry_next  = new_entry_reg;
        new_rem_next    = new_rem_reg;
        status_next     = status_reg;
        pend_name_next  = pend_name_reg;
        pend_valid_next = pend_valid_reg;
        ram_we          = 1'b0;
        ram_waddr       = stq_pkg::slot_addr(head_reg, k_reg);
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = head_reg;
        emit            = '0;
        case (state_reg)
            stq_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    pend_valid_next         = 1'b0;
                    new_rem_next            = in_data.time_value[stq_pkg::TIME_W-2:0];
                    new_entry_next.deadline = now_reg
                                              + {1'b0, in_data.time_value[stq_pkg::TIME_W-2:0]};
                    new_entry_next.name     = in_data.entry_name[stq_pkg::NAME_W-1:0];
                    k_next                  = count_reg[stq_pkg::ADDR_W-1:0];
                    if (in_data.req_type == stq_pkg::REQ_TICK)
                    begin
                        // Advance time and fetch the head entry
                        if (!q_empty)
                        begin
                            now_next  = now_reg + stq_pkg::TIME_W'(1);
                            ram_re    = 1'b1;
                            ram_raddr = head_reg;
                        end
                    end
                    else if (t_bad)
                    begin
                        status_next = stq_pkg::ST_BAD_TIME;
                    end
                    else if (q_full)
                    begin
                        status_next = stq_pkg::ST_FULL;
                    end
                    else
                    begin
                        status_next = stq_pkg::ST_ACCEPTED;
                        // Fetch the tail entry to start the walk
                        if (!q_empty)
                        begin
                            ram_re    = 1'b1;
                            ram_raddr = stq_pkg::slot_addr(head_reg, last_off);
                        end
                    end
                end
            end
            stq_pkg::S_INS_SCAN:
            begin
                // Move a later entry up one position and fetch the one before
                if (!scan_stop)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = stq_pkg::slot_addr(head_reg, k_reg);
                    ram_wdata = ram_rdata;
                    k_next    = k_reg - stq_pkg::A_ONE;
                    if (k_reg != stq_pkg::A_ONE)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = stq_pkg::slot_addr(head_reg,
                                        k_reg - stq_pkg::A_ONE - stq_pkg::A_ONE);
                    end
                end
            end
            stq_pkg::S_INS_PLACE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = stq_pkg::slot_addr(head_reg, k_reg);
                ram_wdata  = new_entry_reg;
                count_next = count_reg + stq_pkg::C_ONE;
            end
            stq_pkg::S_INS_DONE:
            begin
                emit.valid             = can_load;
                emit.data.status       = status_reg;
                emit.data.expired_name = '0;
                emit.data.last_of_run  = 1'b1;
            end
            stq_pkg::S_TICK_CHK:
            begin
                if (step_ok)
                begin
                    emit.valid             = pend_valid_reg;
                    emit.data.status       = stq_pkg::ST_EXPIRED;
                    emit.data.expired_name = pend_name_ext;
                    emit.data.last_of_run  = !expire;
                    if (expire)
                    begin
                        // Drop the head, hold its name until the next check
                        pend_name_next  = ram_rdata.name;
                        pend_valid_next = 1'b1;
                        head_next       = head_inc;
                        count_next      = count_dec;
                        if (count_reg != stq_pkg::C_ONE)
                        begin
                            ram_re    = 1'b1;
                            ram_raddr = head_inc;
                        end
                    end
                end
            end
            stq_pkg::S_TICK_LAST:
            begin
                emit.valid             = can_load;
                emit.data.status       = stq_pkg::ST_EXPIRED;
                emit.data.expired_name = pend_name_ext;
                emit.data.last_of_run  = 1'b1;
            end
            default:
            begin
                emit = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= stq_pkg::S_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            now_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            now_reg        <= now_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        new_entry_reg <= new_entry_next;
        new_rem_reg   <= new_rem_next;
        status_reg    <= status_next;
        pend_name_reg <= pend_name_next;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= stq_pkg::DEPTH_C)
        else $error("entry count above queue depth");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid |-> can_load)
        else $error("result issued while output register is occupied");

    a_tick_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == stq_pkg::S_TICK_CHK) |-> (count_reg != '0))
        else $error("expiry check on an empty queue");

    a_place_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == stq_pkg::S_INS_PLACE) |=> (count_reg == $past(count_reg) + stq_pkg::C_ONE))
        else $error("insert did not grow the queue by one");

    a_walk_write: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read and write of the same slot in one cycle");
`endif

endmodule

[rtl/sorted_timer_queue.sv]
// Top level of the sorted timer queue: entry RAM, controller and the
// result output register. Depends on stq_pkg, stq_ram and stq_ctrl.
//
// Sorted timer queue. Holds up to QUEUE_DEPTH named timers in ascending order
// of remaining time in a single-port-write, single-port-read RAM used as a
// circular buffer; entries keep an absolute deadline against an internal tick
// counter, so a tick costs no pass over the store. A rejected insert request
// goes straight to issuing its status. An accepted insert on an empty queue
// writes the entry; otherwise the walk first reads the tail entry and moves
// each entry with a later time up one slot (one RAM read and write per
// cycle) before the new entry is written. Its status then waits for room in
// the output register. A tick on an empty queue issues no result; otherwise
// it advances time and reads the head entry, one RAM read per expiry; each
// expired name is held back one step so that its last_of_run flag is known
// before it is issued.
// A new request is taken once the previous one is done and has issued any result;
// the output register lets that result wait without holding up the input.
module sorted_timer_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  stq_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output stq_pkg::out_t out_data
);

    logic                       can_load;
    stq_pkg::emit_t             emit;
    logic                       ram_we;
    logic [stq_pkg::ADDR_W-1:0] ram_waddr;
    stq_pkg::entry_t            ram_wdata;
    logic                       ram_re;
    logic [stq_pkg::ADDR_W-1:0] ram_raddr;
    logic [stq_pkg::ENTRY_W-1:0] ram_rdata_raw;
    stq_pkg::entry_t            ram_rdata;
    logic                       out_valid_reg, out_valid_next;
    stq_pkg::out_t              out_data_reg, out_data_next;

    assign ram_rdata = stq_pkg::entry_t'(ram_rdata_raw);

    stq_ram #(
        .WIDTH (stq_pkg::ENTRY_W),
        .DEPTH (stq_pkg::QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    stq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .can_load  (can_load),
        .emit      (emit),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Load a new result when the register is empty or being drained
    always_comb
    begin
        can_load       = !out_valid_reg || out_ready;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit.valid)
        begin
            out_valid_next = 1'b1;
            out_data_next  = emit.data;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
